// ----- sv/sacs_pkg.sv -----
// shared types and constants of the striped access chunk splitter
`timescale 1ns / 1ps

package sacs_pkg;

    localparam int OFFSET_W         = 40;
    localparam int COUNT_W          = 16;
    localparam int NODE_W           = 10;
    localparam int LEN_W            = 11;
    localparam int NCFG_W           = 11;
    localparam int NODE_LIMIT       = 1024;
    localparam int STRIPE_BYTES_DEF = 1024;
    localparam int MAX_CHUNKS_DEF   = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_NODE,
        ST_MUL_BASE,
        ST_CHUNK
    } state_t;

    typedef struct packed {
        logic                opcode;
        logic [OFFSET_W-1:0] offset;
        logic [COUNT_W-1:0]  byte_count;
    } req_t;

    typedef struct packed {
        logic                direction;
        logic [NODE_W-1:0]   target_node;
        logic [OFFSET_W-1:0] displacement;
        logic [LEN_W-1:0]    chunk_length;
        logic                last;
    } res_t;

endpackage

// ----- sv/striped_access_chunk_splitter.sv -----
// top level: splits a striped-memory access into per-node chunks
`timescale 1ns / 1ps

// striped access chunk splitter
// an item (opcode, offset, byte_count) is taken on req at a clock edge where
// start is high and busy is low. the block then cuts the byte range into
// chunks that never cross a stripe boundary and emits one result per chunk on
// result, each marked by strobe for exactly one cycle; result.last flags the
// final chunk. an item with a byte count of zero gives no result
// the stripe size is a power of two, so the stripe index and the in-stripe
// position are a shift and a mask of the offset. one shared add/subtract unit
// then does the long arithmetic in sequence: a 40-step restoring divide of
// the stripe index by the node count, then a shift-add multiply of the block
// index by the stripe size (one step per stripe-size bit, 11 for 1024).
// after that one chunk goes out per cycle
// busy is already low when the final chunk is strobed. a request running past
// the top of the 40-bit space carries on at node 0, block 0
// the receiver cannot stall: results are not held back
// node_count is written through cfg_wr_en / cfg_wr_data; the user writes it
// only while busy is low, which the block does not enforce; zero counts as
// one node, anything above 1024 as 1024
// reset (rst_n low, asynchronous) returns to idle with node_count = 1

module striped_access_chunk_splitter #(
    parameter int STRIPE_BYTES = sacs_pkg::STRIPE_BYTES_DEF,
    parameter int MAX_CHUNKS   = sacs_pkg::MAX_CHUNKS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  sacs_pkg::req_t              req,
    input  logic                        cfg_wr_en,
    input  logic [sacs_pkg::NCFG_W-1:0] cfg_wr_data,
    output logic                        strobe,
    output sacs_pkg::res_t              result
);

    localparam int OW        = sacs_pkg::OFFSET_W;
    localparam int NW        = sacs_pkg::NODE_W;
    localparam int KCW       = sacs_pkg::COUNT_W;
    localparam int NCW       = sacs_pkg::NCFG_W;
    localparam int LW        = sacs_pkg::LEN_W;
    // stripe size and the in-stripe position
    localparam int SW        = $clog2(STRIPE_BYTES + 1);
    // offset bits below the stripe index
    localparam int STRIPE_SH = $clog2(STRIPE_BYTES);
    // divisor / remainder width, the node count
    localparam int DW        = NCW;
    // chunk length arithmetic width
    localparam int CW        = (SW > KCW) ? SW : KCW;
    localparam int KW        = $clog2(MAX_CHUNKS + 1);
    localparam int STEP_W    = $clog2(OW);
    localparam longint BOUND = longint'(MAX_CHUNKS - 1) * longint'(STRIPE_BYTES);

    localparam logic [SW-1:0]     STRIPE_S  = SW'(STRIPE_BYTES);
    localparam logic [OW-1:0]     STRIPE_O  = OW'(STRIPE_BYTES);
    localparam logic [KCW-1:0]    BOUND_K   = KCW'(BOUND);
    localparam logic [KW-1:0]     MAXC_K    = KW'(MAX_CHUNKS);
    localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(OW - 1);
    localparam logic [STEP_W-1:0] MUL_STEPS = STEP_W'(SW - 1);
    localparam logic [NCW-1:0]    NODE_MAX  = NCW'(sacs_pkg::NODE_LIMIT);

    sacs_pkg::state_t state_reg, state_next;

    logic [NCW-1:0]    node_count_reg, node_count_next;
    logic              dir_reg, dir_next;
    logic [OW-1:0]     pos_reg, pos_next;
    logic [KCW-1:0]    left_reg, left_next;
    logic [NCW-1:0]    nodes_reg, nodes_next;
    logic [KW-1:0]     count_reg, count_next;
    logic [STEP_W-1:0] step_reg, step_next;
    // dividend / quotient shift register, also the multiplicand
    logic [OW-1:0]     dvd_reg, dvd_next;
    logic [DW-1:0]     rem_reg, rem_next;
    logic [SW-1:0]     mplier_reg, mplier_next;
    // block * stripe, built up by the multiply
    logic [OW-1:0]     base_reg, base_next;
    logic [SW-1:0]     within_reg, within_next;
    logic [NW-1:0]     node_reg, node_next;
    logic              strobe_reg, strobe_next;
    sacs_pkg::res_t    result_reg, result_next;

    // shared add / subtract unit
    logic [OW-1:0] alu_a, alu_b;
    logic          alu_sub;
    logic [OW:0]   alu_sum;

    // divide step
    logic [DW:0]   rem_shift;
    logic [DW-1:0] divisor;
    logic          no_borrow;
    logic [DW-1:0] rem_step;

    // request setup
    logic           accept;
    logic [KCW-1:0] left_in;
    logic [NCW-1:0] nodes_eff;

    // chunk step
    logic [CW-1:0]  room, left_c, len;
    logic [KCW-1:0] left_after;
    logic [OW:0]    pos_sum;
    logic [KW-1:0]  count_inc;
    logic           chunk_done;
    logic [NCW-1:0] node_inc;
    logic           node_wrap;

    assign busy   = (state_reg != sacs_pkg::ST_IDLE);
    assign accept = start && !busy;
    assign strobe = strobe_reg;
    assign result = result_reg;

    // clamp to the count that always fits the chunk budget
    always_comb
    begin
        if (32'(req.byte_count) > 32'(BOUND))
        begin
            left_in = BOUND_K;
        end
        else
        begin
            left_in = req.byte_count;
        end
    end

    always_comb
    begin
        if (node_count_reg == '0)
        begin
            nodes_eff = NCW'(1);
        end
        else if (node_count_reg > NODE_MAX)
        begin
            nodes_eff = NODE_MAX;
        end
        else
        begin
            nodes_eff = node_count_reg;
        end
    end

    // restoring divide step, operands come through the shared unit
    assign rem_shift = {rem_reg, dvd_reg[OW-1]};
    assign divisor   = nodes_reg;
    assign no_borrow = alu_sum[OW];
    assign rem_step  = no_borrow ? alu_sum[DW-1:0] : rem_shift[DW-1:0];

    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            sacs_pkg::ST_DIV_NODE:
            begin
                alu_a   = OW'(rem_shift);
                alu_b   = OW'(divisor);
                alu_sub = 1'b1;
            end
            sacs_pkg::ST_MUL_BASE:
            begin
                alu_a = base_reg;
                alu_b = dvd_reg;
            end
            default:
            begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (OW+1)'(alu_sub);

    // one chunk: up to the stripe end or the bytes left
    assign room       = CW'(STRIPE_S) - CW'(within_reg);
    assign left_c     = CW'(left_reg);
    assign len        = (left_c < room) ? left_c : room;
    assign left_after = left_reg - len[KCW-1:0];
    assign pos_sum    = {1'b0, pos_reg} + (OW+1)'(len);
    assign count_inc  = count_reg + KW'(1);
    assign chunk_done = (left_after == '0) || (count_inc == MAXC_K);
    assign node_inc   = NCW'(node_reg) + NCW'(1);
    assign node_wrap  = (node_inc == nodes_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sacs_pkg::ST_IDLE:
            begin
                if (accept && (left_in != '0))
                begin
                    state_next = sacs_pkg::ST_DIV_NODE;
                end
            end
            sacs_pkg::ST_DIV_NODE:
            begin
                if (step_reg == '0)
                begin
                    state_next = sacs_pkg::ST_MUL_BASE;
                end
            end
            sacs_pkg::ST_MUL_BASE:
            begin
                if (step_reg == '0)
                begin
                    state_next = sacs_pkg::ST_CHUNK;
                end
            end
            sacs_pkg::ST_CHUNK:
            begin
                if (chunk_done)
                begin
                    state_next = sacs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sacs_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        node_count_next = node_count_reg;
        dir_next        = dir_reg;
        pos_next        = pos_reg;
        left_next       = left_reg;
        nodes_next      = nodes_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        mplier_next     = mplier_reg;
        base_next       = base_reg;
        within_next     = within_reg;
        node_next       = node_reg;
        strobe_next     = 1'b0;
        result_next     = result_reg;

        if (cfg_wr_en)
        begin
            node_count_next = cfg_wr_data;
        end

        case (state_reg)
            sacs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    dir_next    = req.opcode;
                    pos_next    = req.offset;
                    left_next   = left_in;
                    nodes_next  = nodes_eff;
                    count_next  = '0;
                    // stripe index by shift, in-stripe position by mask
                    dvd_next    = req.offset >> STRIPE_SH;
                    within_next = SW'(req.offset[STRIPE_SH-1:0]);
                    rem_next    = '0;
                    step_next   = DIV_STEPS;
                end
            end
            sacs_pkg::ST_DIV_NODE:
            begin
                dvd_next  = {dvd_reg[OW-2:0], no_borrow};
                rem_next  = rem_step;
                step_next = step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    // quotient is the block index, remainder the node
                    node_next   = rem_step[NW-1:0];
                    base_next   = '0;
                    mplier_next = STRIPE_S;
                    step_next   = MUL_STEPS;
                end
            end
            sacs_pkg::ST_MUL_BASE:
            begin
                if (mplier_reg[0])
                begin
                    base_next = alu_sum[OW-1:0];
                end
                dvd_next    = {dvd_reg[OW-2:0], 1'b0};
                mplier_next = mplier_reg >> 1;
                step_next   = step_reg - STEP_W'(1);
            end
            sacs_pkg::ST_CHUNK:
            begin
                strobe_next              = 1'b1;
                result_next.direction    = dir_reg;
                result_next.target_node  = node_reg;
                result_next.displacement = base_reg + OW'(within_reg);
                result_next.chunk_length = len[LW-1:0];
                result_next.last         = (left_after == '0);
                left_next                = left_after;
                pos_next                 = pos_sum[OW-1:0];
                count_next               = count_inc;
                if (!chunk_done)
                begin
                    // next stripe starts at its first byte on the next node
                    within_next = '0;
                    if (pos_sum[OW])
                    begin
                        // ran past the top of the address space: stripe 0
                        node_next = '0;
                        base_next = '0;
                    end
                    else if (node_wrap)
                    begin
                        node_next = '0;
                        base_next = base_reg + STRIPE_O;
                    end
                    else
                    begin
                        node_next = node_inc[NW-1:0];
                    end
                end
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sacs_pkg::ST_IDLE;
            node_count_reg <= NCW'(1);
            strobe_reg     <= 1'b0;
            step_reg       <= '0;
            count_reg      <= '0;
            mplier_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            strobe_reg     <= strobe_next;
            step_reg       <= step_next;
            count_reg      <= count_next;
            mplier_reg     <= mplier_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        dir_reg    <= dir_next;
        pos_reg    <= pos_next;
        left_reg   <= left_next;
        nodes_reg  <= nodes_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        base_reg   <= base_next;
        within_reg <= within_next;
        node_reg   <= node_next;
        result_reg <= result_next;
    end

`ifndef SYNTHESIS
    // results only come out of a chunk cycle of a busy block
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
    else $error("result strobe without a preceding busy cycle");

    // the final chunk leaves the block idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.last) |-> !busy)
    else $error("busy still high after the final chunk");

    // an empty request is dropped at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req.byte_count == '0)) |=> (!busy && !strobe))
    else $error("zero byte request started work");

    // no chunk is empty or longer than a stripe
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> ((result.chunk_length != '0)
                    && (32'(result.chunk_length) <= 32'(STRIPE_BYTES))))
    else $error("chunk length out of range");
`endif

endmodule

// ----- tb/sv/striped_access_chunk_splitter_checker.sv -----
// chunk predictor and result comparator for the striped access chunk splitter
`timescale 1ns / 1ps

module striped_access_chunk_splitter_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  sacs_pkg::req_t              req,
    input  logic                        cfg_wr_en,
    input  logic [sacs_pkg::NCFG_W-1:0] cfg_wr_data,
    input  logic                        strobe,
    input  sacs_pkg::res_t              result,
    input  logic                        end_check,
    output int                          mismatches,
    output int                          outstanding
);

    localparam int OW  = sacs_pkg::OFFSET_W;
    localparam int NDW = sacs_pkg::NODE_W;
    localparam int LNW = sacs_pkg::LEN_W;
    localparam longint unsigned STRIPE      = sacs_pkg::STRIPE_BYTES_DEF;
    localparam longint unsigned COUNT_BOUND =
        (sacs_pkg::MAX_CHUNKS_DEF - 1) * sacs_pkg::STRIPE_BYTES_DEF;
    localparam longint unsigned ADDR_MASK   = (64'd1 << OW) - 1;

    sacs_pkg::res_t              expected_chunks[$];
    logic [sacs_pkg::NCFG_W-1:0] node_reg = 1;
    int                          chunk_no = 0;
    bit                          leftovers_checked = 0;

    initial mismatches = 0;
    initial outstanding = 0;

    task automatic note_failure(input string msg);
        $display("%0t ns  %s", $time, msg);
        mismatches++;
    endtask

    // cut one request into stripe-bounded chunks, push one expectation per chunk
    task automatic split_request(input sacs_pkg::req_t r);
        longint unsigned pos, left, nodes, sidx, in_stripe, len;
        int             n;
        sacs_pkg::res_t c;
        nodes = node_reg;
        if (nodes == 0)
            nodes = 1;
        if (nodes > sacs_pkg::NODE_LIMIT)
            nodes = sacs_pkg::NODE_LIMIT;
        pos  = r.offset;
        left = r.byte_count;
        if (left > COUNT_BOUND)
            left = COUNT_BOUND;
        n = 0;
        while (left > 0 && n < sacs_pkg::MAX_CHUNKS_DEF)
        begin
            sidx      = pos / STRIPE;
            in_stripe = pos % STRIPE;
            len       = STRIPE - in_stripe;
            if (len > left)
                len = left;
            left -= len;
            c.direction    = r.opcode;
            c.target_node  = NDW'(sidx % nodes);
            c.displacement = OW'(((sidx / nodes) * STRIPE + in_stripe) & ADDR_MASK);
            c.chunk_length = LNW'(len);
            c.last         = (left == 0);
            expected_chunks.push_back(c);
            pos = (pos + len) & ADDR_MASK;
            n++;
        end
    endtask

    task automatic compare_chunk(input sacs_pkg::res_t got);
        sacs_pkg::res_t want;
        if (expected_chunks.size() == 0)
        begin
            note_failure($sformatf("unexpected chunk %h", got));
            return;
        end
        want = expected_chunks.pop_front();
        if (got.direction !== want.direction)
            note_failure($sformatf("chunk %0d direction got %0h want %0h",
                                   chunk_no, got.direction, want.direction));
        if (got.target_node !== want.target_node)
            note_failure($sformatf("chunk %0d target_node got %0d want %0d",
                                   chunk_no, got.target_node, want.target_node));
        if (got.displacement !== want.displacement)
            note_failure($sformatf("chunk %0d displacement got %h want %h",
                                   chunk_no, got.displacement, want.displacement));
        if (got.chunk_length !== want.chunk_length)
            note_failure($sformatf("chunk %0d chunk_length got %0d want %0d",
                                   chunk_no, got.chunk_length, want.chunk_length));
        if (got.last !== want.last)
            note_failure($sformatf("chunk %0d last got %0h want %0h",
                                   chunk_no, got.last, want.last));
        chunk_no++;
    endtask

    // results of the cycle are checked before a new item is queued
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_reg = 1;
            expected_chunks.delete();
        end
        else
        begin
            if (strobe)
                compare_chunk(result);
            if (cfg_wr_en)
                node_reg = cfg_wr_data;
            if (start && !busy)
                split_request(req);
            if (end_check && !leftovers_checked)
            begin
                leftovers_checked = 1;
                if (expected_chunks.size() != 0)
                    note_failure($sformatf("%0d chunks never arrived",
                                           expected_chunks.size()));
            end
        end
        outstanding = expected_chunks.size();
    end

endmodule

// ----- tb/sv/striped_access_chunk_splitter_tb.sv -----
// stimulus and verdict for the striped access chunk splitter
`timescale 1ns / 1ps

module striped_access_chunk_splitter_tb;

    localparam int OW  = sacs_pkg::OFFSET_W;
    localparam int CW  = sacs_pkg::COUNT_W;
    localparam int NCW = sacs_pkg::NCFG_W;
    localparam logic [OW-1:0] TOP_ADDR = {OW{1'b1}};

    logic           clk = 1'b0;
    logic           rst_n;
    logic           start;
    logic           busy;
    sacs_pkg::req_t req;
    logic           cfg_wr_en;
    logic [NCW-1:0] cfg_wr_data;
    logic           strobe;
    sacs_pkg::res_t result;
    logic           end_check;
    int             mismatches;
    int             outstanding;

    striped_access_chunk_splitter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .strobe      (strobe),
        .result      (result)
    );

    // watches both channels, predicts the chunks and counts mismatches
    striped_access_chunk_splitter_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .strobe      (strobe),
        .result      (result),
        .end_check   (end_check),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #1 clk = ~clk;

    // hard stop: far beyond the slowest correct run
    initial
    begin
        #3_000_000;
        $display("striped_access_chunk_splitter: mismatch");
        $finish;
    end

    // present one item from a falling edge and hold it until accepted;
    // returns at the falling edge after the accept with start still high,
    // so the caller either drops start or hands over the next item
    task automatic drive_item(input logic op, input logic [OW-1:0] off,
                              input logic [CW-1:0] cnt);
        start          = 1'b1;
        req.opcode     = op;
        req.offset     = off;
        req.byte_count = cnt;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // stop sending and let every expected chunk come out; zero-byte items
    // give nothing to wait on, so allow a full item latency before checking busy
    task automatic settle_block();
        start = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (120) @(negedge clk);
        while (busy)
            @(negedge clk);
    endtask

    task automatic write_node_count(input logic [NCW-1:0] value);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
    endtask

    initial
    begin
        int             idle_pct;
        logic [NCW-1:0] nodes;
        logic [OW-1:0]  off;
        logic [CW-1:0]  cnt;
        logic [63:0]    wide;

        rst_n       = 1'b0;
        start       = 1'b0;
        req         = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        end_check   = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part, node count still at its reset value of one
        drive_item(1'b0, '0, '0);                         // zero bytes: no chunk
        drive_item(1'b0, '0, 16'd1);                      // single byte
        drive_item(1'b1, '0, 16'd1024);                   // exactly one stripe
        drive_item(1'b1, 40'd1023, 16'd2);                // straddles a boundary
        drive_item(1'b0, '0, 16'd64512);                  // right at the clamp bound
        drive_item(1'b1, 40'd513, 16'hFFFF);              // clamped, full 64 chunks
        drive_item(1'b0, 40'd1, 16'd64513);               // one past the bound
        drive_item(1'b1, TOP_ADDR, 16'd3);                // wraps past the top
        drive_item(1'b0, TOP_ADDR - 40'd1023, 16'd2048);  // wraps on a stripe edge
        drive_item(1'b1, TOP_ADDR, '0);                   // zero bytes at the top
        drive_item(1'b0, 40'hAA_AAAA_AAAA, 16'h5555);
        drive_item(1'b1, 40'h55_5555_5555, 16'hAAAA);
        settle_block();

        // a few wide node counts: high node bits and the saturation
        write_node_count(11'd1024);
        drive_item(1'b1, 40'd1024 * 40'd1023, 16'd3072); // crosses node 1023 -> 0
        drive_item(1'b0, TOP_ADDR - 40'd5000, 16'd9000); // wrap with many nodes
        settle_block();
        write_node_count(11'd2047);                       // saturates to 1024
        drive_item(1'b1, 40'd1024 * 40'd1022 + 40'd7, 16'd4096);
        drive_item(1'b0, 40'h80_0000_0000, 16'd1500);
        settle_block();
        write_node_count(11'd0);                          // counts as one node
        drive_item(1'b1, 40'h12_3456_7800, 16'd2500);
        drive_item(1'b0, TOP_ADDR - 40'd10, 16'd20);

        // random phases: 9 node counts x 48 items
        for (int ph = 0; ph < 9; ph++)
        begin
            settle_block();
            case (ph)
                0: nodes = 11'd1024;
                1: nodes = 11'd0;
                2: nodes = 11'd3;
                3: nodes = 11'd2047;
                4: nodes = 11'd7;
                5: nodes = 11'd1;
                6: nodes = NCW'($urandom_range(1, 1024));
                7: nodes = NCW'($urandom_range(0, 2047));
                default: nodes = 11'd2;
            endcase
            write_node_count(nodes);
            // sender idles a quarter of the time, then just over half, then never
            idle_pct = (ph < 3) ? 25 : (ph < 6) ? 52 : 0;

            for (int i = 0; i < 48; i++)
            begin
                // mid-phase hold-off until the block has drained
                if (i == 24)
                    settle_block();

                wide = {$urandom, $urandom};
                case ($urandom_range(0, 7))
                    0, 1, 2, 3: off = wide[OW-1:0];
                    4, 5:
                    begin
                        // at or just below a stripe boundary
                        off = wide[OW-1:0];
                        off[9:0] = '0;
                        off = off - OW'($urandom_range(0, 8));
                    end
                    6: off = TOP_ADDR - OW'($urandom_range(0, 4096));
                    default: off = OW'($urandom_range(0, 70000));
                endcase

                // mostly short requests so the run stays quick
                case ($urandom_range(0, 19))
                    0, 1: cnt = '0;
                    2, 3, 4, 5, 6, 7, 8, 9, 10, 11: cnt = CW'($urandom_range(1, 3000));
                    12, 13: cnt = CW'($urandom_range(60000, 65535));
                    14, 15, 16, 17: cnt = CW'($urandom_range(1, 16));
                    default: cnt = CW'($urandom);
                endcase

                drive_item(1'($urandom), off, cnt);

                // idle gap of random length so it lands on any phase of the work
                if ($urandom_range(0, 99) < idle_pct)
                begin
                    start = 1'b0;
                    repeat ($urandom_range(1, 160)) @(negedge clk);
                end
            end
        end

        // drain, then let the checker flag anything still owed
        settle_block();
        end_check = 1'b1;
        @(negedge clk);

        if (mismatches == 0)
            $display("striped_access_chunk_splitter: match");
        else
            $display("striped_access_chunk_splitter: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/sacs_pkg.sv
sv/striped_access_chunk_splitter.sv
tb/sv/striped_access_chunk_splitter_checker.sv
tb/sv/striped_access_chunk_splitter_tb.sv
